// ===== rtl/css_pkg.sv =====
package css_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int COUNT_BITS   = 24;
  localparam int CFG_BITS     = 16;
  localparam int CFG_IDX_BITS = 2;
  localparam int SUM_BITS     = SAMPLE_BITS + COUNT_BITS;
  localparam int TOTAL_BITS   = COUNT_BITS + 2;
  localparam int NUM_BITS     = SUM_BITS + 3;
  localparam int VALUE_BITS   = 25;
  localparam int ID_BITS      = 4;
  localparam int N_CLASS      = 3;
  localparam int N_STATS      = 14;
  localparam int STEP_BITS    = $clog2(NUM_BITS);
  localparam int CMP_BITS     = (SAMPLE_BITS > CFG_BITS) ? SAMPLE_BITS : CFG_BITS;

  typedef logic        [1:0]              req_t;
  typedef logic signed [SAMPLE_BITS-1:0]  sample_t;
  typedef logic        [COUNT_BITS-1:0]   count_t;
  typedef logic signed [VALUE_BITS-1:0]   value_t;
  typedef logic        [ID_BITS-1:0]      stat_id_t;
  typedef logic        [CFG_IDX_BITS-1:0] cfg_idx_t;
  typedef logic signed [CFG_BITS-1:0]     cfg_val_t;

  localparam req_t REQ_ADD    = 2'd0;
  localparam req_t REQ_REPORT = 2'd1;
  localparam req_t REQ_CLEAR  = 2'd2;

  localparam cfg_idx_t CFG_LOW_LIMIT  = 2'd0;
  localparam cfg_idx_t CFG_HIGH_LIMIT = 2'd1;
  localparam cfg_idx_t CFG_BAND_LOW   = 2'd2;
  localparam cfg_idx_t CFG_BAND_HIGH  = 2'd3;

  localparam cfg_val_t LOW_LIMIT_RST  = cfg_val_t'(100);
  localparam cfg_val_t HIGH_LIMIT_RST = cfg_val_t'(300);
  localparam cfg_val_t BAND_LOW_RST   = cfg_val_t'(150);
  localparam cfg_val_t BAND_HIGH_RST  = cfg_val_t'(250);

  localparam count_t CNT_MAX = '1;

  localparam stat_id_t SID_CNT_LOW  = 4'd0;
  localparam stat_id_t SID_CNT_MID  = 4'd1;
  localparam stat_id_t SID_CNT_HIGH = 4'd2;
  localparam stat_id_t SID_MAX_LOW  = 4'd3;
  localparam stat_id_t SID_MAX_MID  = 4'd4;
  localparam stat_id_t SID_MAX_HIGH = 4'd5;
  localparam stat_id_t SID_MIN_LOW  = 4'd6;
  localparam stat_id_t SID_MIN_MID  = 4'd7;
  localparam stat_id_t SID_MIN_HIGH = 4'd8;
  localparam stat_id_t SID_ALL_MAX  = 4'd9;
  localparam stat_id_t SID_ALL_MIN  = 4'd10;
  localparam stat_id_t SID_BAND_CNT = 4'd11;
  localparam stat_id_t SID_MEAN     = 4'd12;
  localparam stat_id_t SID_OVF      = 4'd13;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SCALE,
    S_DIV,
    S_ROUND,
    S_EMIT
  } css_state_t;

  typedef struct packed {
    logic     upd;
    logic     clr;
    logic     div_load;
    logic     div_scale;
    logic     div_step;
    logic     div_round;
    logic     out_load;
    stat_id_t item;
  } css_cmd_t;

endpackage

// ===== rtl/css_chan_if.sv =====
interface css_in_if;
  import css_pkg::*;

  logic    valid;
  logic    ready;
  req_t    req_type;
  sample_t sample;

  modport source (output valid, req_type, sample, input ready);
  modport sink   (input valid, req_type, sample, output ready);
endinterface

interface css_out_if;
  import css_pkg::*;

  logic     valid;
  logic     ready;
  stat_id_t stat_id;
  value_t   stat_value;
  logic     stat_valid;
  logic     last;

  modport source (output valid, stat_id, stat_value, stat_valid, last, input ready);
  modport sink   (input valid, stat_id, stat_value, stat_valid, last, output ready);
endinterface

// ===== rtl/css_ctrl.sv =====
module css_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  css_pkg::req_t     in_req,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  output css_pkg::css_cmd_t cmd
);
  import css_pkg::*;

  css_state_t           state_r, state_nxt;
  logic [STEP_BITS-1:0] step_r, step_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 accept;
  logic                 out_free;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_req == REQ_REPORT) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        state_nxt = S_DIV;
        step_nxt  = '0;
      end
      S_DIV: begin
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_BITS'(NUM_BITS - 1)) begin
          state_nxt = S_ROUND;
        end
      end
      S_ROUND: begin
        state_nxt = S_EMIT;
        step_nxt  = '0;
      end
      S_EMIT: begin
        if (out_free) begin
          step_nxt = step_r + 1'b1;
          if (step_r == STEP_BITS'(N_STATS - 1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.item      = step_r[ID_BITS-1:0];
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.upd  = in_valid && in_req == REQ_ADD;
        cmd.clr  = in_valid && in_req == REQ_CLEAR;
      end
      S_LOAD:  cmd.div_load  = 1'b1;
      S_SCALE: cmd.div_scale = 1'b1;
      S_DIV:   cmd.div_step  = 1'b1;
      S_ROUND: cmd.div_round = 1'b1;
      S_EMIT:  cmd.out_load  = out_free;
      default: ;
    endcase
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/css_dp.sv =====
module css_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  css_pkg::css_cmd_t             cmd,
  input  css_pkg::sample_t              sample,
  input  logic                          cfg_we,
  input  css_pkg::cfg_idx_t             cfg_index,
  input  logic [css_pkg::CFG_BITS-1:0]  cfg_wdata,
  output css_pkg::stat_id_t             stat_id,
  output css_pkg::value_t               stat_value,
  output logic                          stat_valid,
  output logic                          last
);
  import css_pkg::*;

  // limits
  cfg_val_t low_limit_r, low_limit_nxt;
  cfg_val_t high_limit_r, high_limit_nxt;
  cfg_val_t band_low_r, band_low_nxt;
  cfg_val_t band_high_r, band_high_nxt;

  // statistics
  count_t                      cnt_r [N_CLASS];
  count_t                      cnt_nxt [N_CLASS];
  count_t                      band_cnt_r, band_cnt_nxt;
  sample_t                     cmax_r [N_CLASS];
  sample_t                     cmax_nxt [N_CLASS];
  sample_t                     cmin_r [N_CLASS];
  sample_t                     cmin_nxt [N_CLASS];
  sample_t                     omax_r, omax_nxt;
  sample_t                     omin_r, omin_nxt;
  logic signed [SUM_BITS-1:0]  sum_r, sum_nxt;
  logic                        ovf_r, ovf_nxt;

  // mean divider
  logic                        neg_r, neg_nxt;
  logic [TOTAL_BITS-1:0]       den_r, den_nxt;
  logic [TOTAL_BITS-1:0]       rem_r, rem_nxt;
  logic [NUM_BITS-1:0]         quo_r, quo_nxt;

  // result register
  stat_id_t                    id_r;
  value_t                      value_r;
  logic                        valid_r;
  logic                        last_r;

  logic signed [CMP_BITS-1:0]  sx;
  logic [N_CLASS-1:0]          cls;
  logic [N_CLASS-1:0]          cnt_full;
  logic                        in_band;
  logic                        any_cnt;
  logic                        ovf_mid;
  logic signed [SUM_BITS:0]    sum_try;
  logic                        sum_of;
  logic [SUM_BITS-1:0]         mag;
  logic [TOTAL_BITS:0]         shifted;
  logic [TOTAL_BITS:0]         diff;
  logic                        ge;
  logic [VALUE_BITS-1:0]       mean_mag;
  value_t                      mean_val;
  value_t                      item_val;
  logic                        item_vld;

  assign sx      = CMP_BITS'(sample);
  assign in_band = sx >= CMP_BITS'(band_low_r) && sx <= CMP_BITS'(band_high_r);
  assign any_cnt = cnt_r[0] != '0 || cnt_r[1] != '0 || cnt_r[2] != '0;

  always_comb begin
    cls = '0;
    if (sx < CMP_BITS'(low_limit_r)) begin
      cls[0] = 1'b1;
    end else if (sx <= CMP_BITS'(high_limit_r)) begin
      cls[1] = 1'b1;
    end else begin
      cls[2] = 1'b1;
    end
  end

  always_comb begin
    for (int c = 0; c < N_CLASS; c++) begin
      cnt_full[c] = cnt_r[c] == CNT_MAX;
    end
  end

  assign ovf_mid = ovf_r || (|(cls & cnt_full)) || (in_band && band_cnt_r == CNT_MAX);
  assign sum_try = (SUM_BITS+1)'(sum_r) + (SUM_BITS+1)'(sample);
  assign sum_of  = sum_try[SUM_BITS] != sum_try[SUM_BITS-1];

  always_comb begin
    low_limit_nxt  = low_limit_r;
    high_limit_nxt = high_limit_r;
    band_low_nxt   = band_low_r;
    band_high_nxt  = band_high_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOW_LIMIT:  low_limit_nxt  = cfg_wdata;
        CFG_HIGH_LIMIT: high_limit_nxt = cfg_wdata;
        CFG_BAND_LOW:   band_low_nxt   = cfg_wdata;
        CFG_BAND_HIGH:  band_high_nxt  = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    band_cnt_nxt = band_cnt_r;
    omax_nxt     = omax_r;
    omin_nxt     = omin_r;
    sum_nxt      = sum_r;
    ovf_nxt      = ovf_r;
    for (int c = 0; c < N_CLASS; c++) begin
      cnt_nxt[c]  = cnt_r[c];
      cmax_nxt[c] = cmax_r[c];
      cmin_nxt[c] = cmin_r[c];
      if (cmd.upd && cls[c]) begin
        if (!cnt_full[c]) begin
          cnt_nxt[c] = cnt_r[c] + 1'b1;
        end
        if (cnt_r[c] == '0) begin
          cmax_nxt[c] = sample;
          cmin_nxt[c] = sample;
        end else begin
          if (sample > cmax_r[c]) cmax_nxt[c] = sample;
          if (sample < cmin_r[c]) cmin_nxt[c] = sample;
        end
      end
      if (cmd.clr) begin
        cnt_nxt[c] = '0;
      end
    end
    if (cmd.upd) begin
      if (!any_cnt) begin
        omax_nxt = sample;
        omin_nxt = sample;
      end else begin
        if (sample > omax_r) omax_nxt = sample;
        if (sample < omin_r) omin_nxt = sample;
      end
      if (in_band && band_cnt_r != CNT_MAX) begin
        band_cnt_nxt = band_cnt_r + 1'b1;
      end
      // sum freezes once any counter saturated or the sum would leave its width
      ovf_nxt = ovf_mid || sum_of;
      if (!ovf_mid && !sum_of) begin
        sum_nxt = sum_try[SUM_BITS-1:0];
      end
    end
    if (cmd.clr) begin
      band_cnt_nxt = '0;
      sum_nxt      = '0;
      ovf_nxt      = 1'b0;
    end
  end

  // mean = round(10 * |sum| / total), halves away from zero, then signed
  assign mag     = sum_r[SUM_BITS-1] ? (~sum_r + 1'b1) : sum_r;
  assign shifted = {rem_r, quo_r[NUM_BITS-1]};
  assign ge      = shifted >= {1'b0, den_r};
  assign diff    = shifted - {1'b0, den_r};

  always_comb begin
    neg_nxt = neg_r;
    den_nxt = den_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    if (cmd.div_load) begin
      neg_nxt = sum_r[SUM_BITS-1];
      den_nxt = TOTAL_BITS'(cnt_r[0]) + TOTAL_BITS'(cnt_r[1]) + TOTAL_BITS'(cnt_r[2]);
      rem_nxt = '0;
      quo_nxt = NUM_BITS'(mag);
    end
    if (cmd.div_scale) begin
      quo_nxt = (quo_r << 3) + (quo_r << 1);
    end
    if (cmd.div_step) begin
      rem_nxt = ge ? diff[TOTAL_BITS-1:0] : shifted[TOTAL_BITS-1:0];
      quo_nxt = {quo_r[NUM_BITS-2:0], ge};
    end
    if (cmd.div_round && {rem_r, 1'b0} >= {1'b0, den_r}) begin
      quo_nxt = quo_r + NUM_BITS'(1);
    end
  end

  assign mean_mag = VALUE_BITS'(quo_r);
  assign mean_val = neg_r ? -value_t'(mean_mag) : value_t'(mean_mag);

  always_comb begin
    item_val = '0;
    item_vld = 1'b1;
    unique case (cmd.item)
      SID_CNT_LOW:  item_val = VALUE_BITS'(cnt_r[0]);
      SID_CNT_MID:  item_val = VALUE_BITS'(cnt_r[1]);
      SID_CNT_HIGH: item_val = VALUE_BITS'(cnt_r[2]);
      SID_MAX_LOW: begin
        item_val = VALUE_BITS'(cmax_r[0]);
        item_vld = cnt_r[0] != '0;
      end
      SID_MAX_MID: begin
        item_val = VALUE_BITS'(cmax_r[1]);
        item_vld = cnt_r[1] != '0;
      end
      SID_MAX_HIGH: begin
        item_val = VALUE_BITS'(cmax_r[2]);
        item_vld = cnt_r[2] != '0;
      end
      SID_MIN_LOW: begin
        item_val = VALUE_BITS'(cmin_r[0]);
        item_vld = cnt_r[0] != '0;
      end
      SID_MIN_MID: begin
        item_val = VALUE_BITS'(cmin_r[1]);
        item_vld = cnt_r[1] != '0;
      end
      SID_MIN_HIGH: begin
        item_val = VALUE_BITS'(cmin_r[2]);
        item_vld = cnt_r[2] != '0;
      end
      SID_ALL_MAX: begin
        item_val = VALUE_BITS'(omax_r);
        item_vld = any_cnt;
      end
      SID_ALL_MIN: begin
        item_val = VALUE_BITS'(omin_r);
        item_vld = any_cnt;
      end
      SID_BAND_CNT: item_val = VALUE_BITS'(band_cnt_r);
      SID_MEAN: begin
        item_val = mean_val;
        item_vld = any_cnt;
      end
      SID_OVF:      item_val = VALUE_BITS'(ovf_r);
      default:      item_vld = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_limit_r  <= LOW_LIMIT_RST;
      high_limit_r <= HIGH_LIMIT_RST;
      band_low_r   <= BAND_LOW_RST;
      band_high_r  <= BAND_HIGH_RST;
      band_cnt_r   <= '0;
      sum_r        <= '0;
      ovf_r        <= 1'b0;
      for (int c = 0; c < N_CLASS; c++) begin
        cnt_r[c] <= '0;
      end
    end else begin
      low_limit_r  <= low_limit_nxt;
      high_limit_r <= high_limit_nxt;
      band_low_r   <= band_low_nxt;
      band_high_r  <= band_high_nxt;
      band_cnt_r   <= band_cnt_nxt;
      sum_r        <= sum_nxt;
      ovf_r        <= ovf_nxt;
      for (int c = 0; c < N_CLASS; c++) begin
        cnt_r[c] <= cnt_nxt[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < N_CLASS; c++) begin
      cmax_r[c] <= cmax_nxt[c];
      cmin_r[c] <= cmin_nxt[c];
    end
    omax_r <= omax_nxt;
    omin_r <= omin_nxt;
    neg_r  <= neg_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    if (cmd.out_load) begin
      id_r    <= cmd.item;
      value_r <= item_vld ? item_val : '0;
      valid_r <= item_vld;
      last_r  <= cmd.item == SID_OVF;
    end
  end

  assign stat_id    = id_r;
  assign stat_value = value_r;
  assign stat_valid = valid_r;
  assign last       = last_r;

endmodule

// ===== rtl/classed_sample_statistics.sv =====
// channel  dir  payload                                    handshake
// in_ch    in   req_type[1:0], sample[15:0] signed         valid/ready
// out_ch   out  stat_id[3:0], stat_value[24:0] signed,     valid/ready
//               stat_valid, last
// cfg_*    in   cfg_index[1:0], cfg_wdata[15:0]            cfg_we, no wait
//
// Add-sample and clear beats are taken without leaving idle; input is ready every cycle while idle.
// A report runs the bit-serial mean divider through load, scale, 43 divide steps and round
// (one quotient bit per cycle), then emits 14 output beats, one per cycle without backpressure.
// Input is stalled from the report beat until the last result is in the output register.
// rst_n (synchronous) clears the counters, sum and overflow flag and reloads the default limits.
module classed_sample_statistics (
  input  logic                         clk,
  input  logic                         rst_n,
  css_in_if.sink                       in_ch,
  css_out_if.source                    out_ch,
  input  logic                         cfg_we,
  input  css_pkg::cfg_idx_t            cfg_index,
  input  logic [css_pkg::CFG_BITS-1:0] cfg_wdata
);
  import css_pkg::*;

  css_cmd_t cmd;

  css_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_req    (in_ch.req_type),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd)
  );

  css_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sample     (in_ch.sample),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .stat_id    (out_ch.stat_id),
    .stat_value (out_ch.stat_value),
    .stat_valid (out_ch.stat_valid),
    .last       (out_ch.last)
  );

  a_report_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && in_ch.req_type == REQ_REPORT |=> !in_ch.ready)
    else $error("input still ready after report beat");

  a_last_is_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.last |-> out_ch.stat_id == SID_OVF)
    else $error("last beat is not the overflow item");

  a_emit_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.last |-> !in_ch.ready)
    else $error("input ready while a report is still being emitted");

  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && out_ch.last |=> !out_ch.valid)
    else $error("result beat right after the end of a report");

endmodule

// ===== verif/classed_sample_statistics_tb.sv =====
`timescale 1ns / 100ps

module classed_sample_statistics_tb;
  import css_pkg::*;

  localparam req_t   REQ_SPARE       = 2'd3;
  localparam int     N_DIR           = 23;
  localparam int     N_PHASES        = 6;
  localparam int     ITEMS_PER_PHASE = 26;
  localparam int     LONG_HOLD       = 200;
  localparam int     SETTLE_CYCLES   = 8;
  localparam int     TAIL_CYCLES     = 80;
  localparam longint SUM_HI          = (longint'(1) << (SUM_BITS - 1)) - 1;
  localparam longint SUM_LO          = -SUM_HI - 1;

  typedef struct packed {
    stat_id_t id;
    value_t   value;
    logic     valid;
    logic     last;
  } stat_beat_t;

  typedef enum {CHK_MODEL, CHK_EMPTY, CHK_TOP} chk_t;

  typedef struct {
    req_t    req;
    sample_t smp;
    chk_t    chk;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  cfg_idx_t cfg_index;
  logic [CFG_BITS-1:0] cfg_wdata;

  css_in_if  in_ch();
  css_out_if out_ch();

  classed_sample_statistics DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // statistics shadow
  cfg_val_t lo_lim, hi_lim, b_lo, b_hi;
  count_t   n_cls [N_CLASS];
  count_t   n_band;
  sample_t  cmax [N_CLASS];
  sample_t  cmin [N_CLASS];
  sample_t  amax, amin;
  logic signed [SUM_BITS-1:0] acc;
  logic     ovf;

  stat_beat_t due_stats[$];
  int n_bad = 0;
  bit no_idle = 1'b0;
  bit hold_armed = 1'b0;

  stat_beat_t empty_rpt [N_STATS] = '{
    '{SID_CNT_LOW,  0, 1'b1, 1'b0}, '{SID_CNT_MID,  0, 1'b1, 1'b0},
    '{SID_CNT_HIGH, 0, 1'b1, 1'b0}, '{SID_MAX_LOW,  0, 1'b0, 1'b0},
    '{SID_MAX_MID,  0, 1'b0, 1'b0}, '{SID_MAX_HIGH, 0, 1'b0, 1'b0},
    '{SID_MIN_LOW,  0, 1'b0, 1'b0}, '{SID_MIN_MID,  0, 1'b0, 1'b0},
    '{SID_MIN_HIGH, 0, 1'b0, 1'b0}, '{SID_ALL_MAX,  0, 1'b0, 1'b0},
    '{SID_ALL_MIN,  0, 1'b0, 1'b0}, '{SID_BAND_CNT, 0, 1'b1, 1'b0},
    '{SID_MEAN,     0, 1'b0, 1'b0}, '{SID_OVF,      0, 1'b1, 1'b1}
  };

  // one sample of 32767 after reset
  stat_beat_t top_rpt [N_STATS] = '{
    '{SID_CNT_LOW,  0,      1'b1, 1'b0}, '{SID_CNT_MID,  0,      1'b1, 1'b0},
    '{SID_CNT_HIGH, 1,      1'b1, 1'b0}, '{SID_MAX_LOW,  0,      1'b0, 1'b0},
    '{SID_MAX_MID,  0,      1'b0, 1'b0}, '{SID_MAX_HIGH, 32767,  1'b1, 1'b0},
    '{SID_MIN_LOW,  0,      1'b0, 1'b0}, '{SID_MIN_MID,  0,      1'b0, 1'b0},
    '{SID_MIN_HIGH, 32767,  1'b1, 1'b0}, '{SID_ALL_MAX,  32767,  1'b1, 1'b0},
    '{SID_ALL_MIN,  32767,  1'b1, 1'b0}, '{SID_BAND_CNT, 0,      1'b1, 1'b0},
    '{SID_MEAN,     327670, 1'b1, 1'b0}, '{SID_OVF,      0,      1'b1, 1'b1}
  };

  dir_row_t dir_rows [N_DIR] = '{
    '{REQ_REPORT, 0,      CHK_EMPTY},
    '{REQ_ADD,    32767,  CHK_MODEL},
    '{REQ_REPORT, 0,      CHK_TOP},
    '{REQ_ADD,    -32768, CHK_MODEL},
    '{REQ_ADD,    99,     CHK_MODEL},
    '{REQ_ADD,    100,    CHK_MODEL},
    '{REQ_ADD,    300,    CHK_MODEL},
    '{REQ_ADD,    301,    CHK_MODEL},
    '{REQ_ADD,    149,    CHK_MODEL},
    '{REQ_ADD,    150,    CHK_MODEL},
    '{REQ_ADD,    250,    CHK_MODEL},
    '{REQ_ADD,    251,    CHK_MODEL},
    '{REQ_SPARE,  -1,     CHK_MODEL},
    '{REQ_REPORT, 0,      CHK_MODEL},
    '{REQ_CLEAR,  -1,     CHK_MODEL},
    '{REQ_REPORT, 0,      CHK_EMPTY},
    '{REQ_ADD,    -1,     CHK_MODEL},
    '{REQ_ADD,    0,      CHK_MODEL},
    '{REQ_ADD,    0,      CHK_MODEL},
    '{REQ_ADD,    0,      CHK_MODEL},
    '{REQ_REPORT, 0,      CHK_MODEL},  // mean -2.5 tenths, rounds away from zero
    '{REQ_ADD,    -2,     CHK_MODEL},
    '{REQ_REPORT, 0,      CHK_MODEL}
  };

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #4_000_000;
    $display("classed_sample_statistics: mismatch");
    $finish;
  end

  function automatic void wipe_stats();
    for (int k = 0; k < N_CLASS; k++) begin
      n_cls[k] = '0;
      cmax[k] = '0;
      cmin[k] = '0;
    end
    n_band = '0;
    amax = '0;
    amin = '0;
    acc = '0;
    ovf = 1'b0;
  endfunction

  function automatic void put_beat(ref stat_beat_t res[$], input stat_id_t id,
                                   input value_t v, input logic ok);
    stat_beat_t b;
    b.id = id;
    b.value = ok ? v : '0;
    b.valid = ok;
    b.last = (id == SID_OVF);
    res.push_back(b);
  endfunction

  task automatic stats_update(input req_t r, input sample_t s, ref stat_beat_t res[$]);
    int k;
    longint nxt, sl, mean_v;
    longint unsigned n, mag, q, rem, t;
    logic any;
    n = longint'(n_cls[0]) + n_cls[1] + n_cls[2];
    any = (n != 0);
    case (r)
      REQ_ADD: begin
        if (s < lo_lim) k = 0;
        else if (s <= hi_lim) k = 1;
        else k = 2;
        if (!any) begin
          amax = s;
          amin = s;
        end else begin
          if (s > amax) amax = s;
          if (s < amin) amin = s;
        end
        if (n_cls[k] == '0) begin
          cmax[k] = s;
          cmin[k] = s;
        end else begin
          if (s > cmax[k]) cmax[k] = s;
          if (s < cmin[k]) cmin[k] = s;
        end
        if (n_cls[k] == CNT_MAX) ovf = 1'b1;
        else n_cls[k]++;
        if (s >= b_lo && s <= b_hi) begin
          if (n_band == CNT_MAX) ovf = 1'b1;
          else n_band++;
        end
        if (!ovf) begin
          nxt = longint'(acc) + longint'(s);
          if (nxt > SUM_HI || nxt < SUM_LO) ovf = 1'b1;
          else acc = nxt;
        end
      end
      REQ_CLEAR: wipe_stats();
      REQ_REPORT: begin
        for (k = 0; k < N_CLASS; k++)
          put_beat(res, stat_id_t'(SID_CNT_LOW + k), value_t'(n_cls[k]), 1'b1);
        for (k = 0; k < N_CLASS; k++)
          put_beat(res, stat_id_t'(SID_MAX_LOW + k), value_t'(cmax[k]), n_cls[k] != '0);
        for (k = 0; k < N_CLASS; k++)
          put_beat(res, stat_id_t'(SID_MIN_LOW + k), value_t'(cmin[k]), n_cls[k] != '0);
        put_beat(res, SID_ALL_MAX, value_t'(amax), any);
        put_beat(res, SID_ALL_MIN, value_t'(amin), any);
        put_beat(res, SID_BAND_CNT, value_t'(n_band), 1'b1);
        mean_v = 0;
        if (any) begin
          sl = acc;
          mag = (sl < 0) ? -sl : sl;
          q = mag / n;
          rem = mag % n;
          t = q * 10 + (20 * rem + n) / (2 * n);
          mean_v = (sl < 0) ? -longint'(t) : longint'(t);
        end
        put_beat(res, SID_MEAN, value_t'(mean_v), any);
        put_beat(res, SID_OVF, value_t'(ovf), 1'b1);
      end
      default: ;
    endcase
  endtask

  task automatic note_mismatch(input string msg);
    $display("%0t ns: %s", $realtime, msg);
    n_bad++;
  endtask

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_beat(input req_t r, input sample_t s, input chk_t chk);
    stat_beat_t got[$];
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.req_type <= r;
    in_ch.sample <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    stats_update(r, s, got);
    case (chk)
      CHK_EMPTY: foreach (empty_rpt[i]) due_stats.push_back(empty_rpt[i]);
      CHK_TOP:   foreach (top_rpt[i]) due_stats.push_back(top_rpt[i]);
      default:   foreach (got[i]) due_stats.push_back(got[i]);
    endcase
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input cfg_val_t v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    case (idx)
      CFG_LOW_LIMIT:  lo_lim = v;
      CFG_HIGH_LIMIT: hi_lim = v;
      CFG_BAND_LOW:   b_lo = v;
      default:        b_hi = v;
    endcase
    @(negedge clk);
  endtask

  task automatic drain();
    while (due_stats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic sample_t pick_sample();
    int base, v;
    case ($urandom_range(0, 9))
      0, 1: base = lo_lim;
      2, 3: base = hi_lim;
      4:    base = b_lo;
      5:    base = b_hi;
      6, 7, 8: return sample_t'($urandom);
      default: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    endcase
    v = base + int'($urandom_range(0, 6)) - 3;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return sample_t'(v);
  endfunction

  // result side ready: random stalls plus one long hold-off
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_armed && out_ch.valid) begin
        hold_armed = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (!no_idle && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : watch_out
    stat_beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (due_stats.size() == 0) begin
        note_mismatch($sformatf("unexpected beat id %0d value %0d", out_ch.stat_id,
                                out_ch.stat_value));
      end else begin
        want = due_stats.pop_front();
        if (out_ch.stat_id !== want.id)
          note_mismatch($sformatf("stat_id %0d, want %0d", out_ch.stat_id, want.id));
        if (out_ch.stat_value !== want.value)
          note_mismatch($sformatf("id %0d stat_value %0d, want %0d", want.id,
                                  out_ch.stat_value, want.value));
        if (out_ch.stat_valid !== want.valid)
          note_mismatch($sformatf("id %0d stat_valid %b, want %b", want.id,
                                  out_ch.stat_valid, want.valid));
        if (out_ch.last !== want.last)
          note_mismatch($sformatf("id %0d last %b, want %b", want.id, out_ch.last,
                                  want.last));
      end
    end
  end

  initial begin
    int u;
    req_t r;
    sample_t s;
    cfg_val_t lo, hi, blo, bhi;
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_ADD;
    in_ch.sample = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_LOW_LIMIT;
    cfg_wdata = '0;
    lo_lim = LOW_LIMIT_RST;
    hi_lim = HIGH_LIMIT_RST;
    b_lo = BAND_LOW_RST;
    b_hi = BAND_HIGH_RST;
    wipe_stats();
    wait (rst_n === 1'b1);
    @(negedge clk);

    foreach (dir_rows[i]) send_beat(dir_rows[i].req, dir_rows[i].smp, dir_rows[i].chk);
    in_ch.valid <= 1'b0;
    drain();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin
          lo = 16'sh8000; hi = 16'sh7fff; blo = 16'sh8000; bhi = 16'sh7fff;
        end
        1: begin  // crossed extremes
          lo = 16'sh7fff; hi = 16'sh8000; blo = 16'sh7fff; bhi = 16'sh8000;
        end
        3: begin
          lo = '0; hi = '0; blo = '0; bhi = '0;
        end
        N_PHASES - 1: begin
          lo = LOW_LIMIT_RST; hi = HIGH_LIMIT_RST; blo = BAND_LOW_RST; bhi = BAND_HIGH_RST;
        end
        default: begin
          lo = cfg_val_t'($urandom); hi = cfg_val_t'($urandom);
          blo = cfg_val_t'($urandom); bhi = cfg_val_t'($urandom);
        end
      endcase
      write_reg(CFG_LOW_LIMIT, lo);
      write_reg(CFG_HIGH_LIMIT, hi);
      write_reg(CFG_BAND_LOW, blo);
      write_reg(CFG_BAND_HIGH, bhi);
      cfg_we <= 1'b0;
      if (ph == 0) hold_armed = 1'b1;
      no_idle = (ph == N_PHASES - 1);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        u = $urandom_range(0, 99);
        s = pick_sample();
        if (u < 78) r = REQ_ADD;
        else if (u < 88) r = REQ_REPORT;
        else if (u < 94) r = REQ_CLEAR;
        else r = REQ_SPARE;
        send_beat(r, s, CHK_MODEL);
      end
      in_ch.valid <= 1'b0;
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_bad == 0 && due_stats.size() == 0) begin
      $display("classed_sample_statistics: match");
    end else begin
      $display("classed_sample_statistics: mismatch");
    end
    $finish;
  end

endmodule
